/* sv/tcspq_pkg.sv */
// shared types and constants for the three-class strict priority queue
// no dependencies
`default_nettype none

package tcspq_pkg;

  localparam int TAG_BITS    = 16;
  localparam int DEPTH_DEF   = 128;
  localparam int NUM_CLASSES = 3;

  // class codes on the command port
  localparam logic [2:0] CLASS_HI  = 3'd1;
  localparam logic [2:0] CLASS_MID = 3'd2;
  localparam logic [2:0] CLASS_LO  = 3'd3;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_PUSHED    = 3'd0,
    ST_DROPPED   = 3'd1,
    ST_BAD_CLASS = 3'd2,
    ST_POPPED    = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    KIND_PUSH = 2'd0,
    KIND_POP  = 2'd1,
    KIND_BAD  = 2'd2
  } kind_t;

  typedef enum logic {
    BK_RUN = 1'b0,
    BK_POP = 1'b1
  } back_state_t;

  typedef struct packed {
    logic                op;
    logic [15:0]         tag;
    logic [2:0]          prio_class;
  } cmd_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [15:0]         out_tag;
    logic [1:0]          out_class;
  } result_t;

  // classified command between front and back
  typedef struct packed {
    kind_t               kind;
    logic [1:0]          cls;
    logic [TAG_BITS-1:0] tag;
  } work_t;

  typedef struct packed {
    logic                valid;
    work_t               work;
  } qout_t;

endpackage

`default_nettype wire

/* sv/tcspq_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module tcspq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/tcspq_front.sv */
// front end: takes commands, classifies them and holds them in a two-entry queue
// depends on tcspq_pkg
`default_nettype none

module tcspq_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output      logic              busy,
  input  wire tcspq_pkg::cmd_t   cmd,
  output      tcspq_pkg::qout_t  qout,
  input  wire logic              take
);

  tcspq_pkg::work_t q [0:1];
  logic             wp;
  logic             rp;
  logic [1:0]       cnt;
  tcspq_pkg::work_t incoming;
  logic             push;

  always_comb begin
    incoming.tag  = cmd.tag;
    incoming.cls  = 2'd0;
    incoming.kind = tcspq_pkg::KIND_BAD;
    if (cmd.op == tcspq_pkg::OP_POP) begin
      incoming.kind = tcspq_pkg::KIND_POP;
    end else begin
      unique case (cmd.prio_class)
        tcspq_pkg::CLASS_HI: begin
          incoming.kind = tcspq_pkg::KIND_PUSH;
          incoming.cls  = 2'd0;
        end
        tcspq_pkg::CLASS_MID: begin
          incoming.kind = tcspq_pkg::KIND_PUSH;
          incoming.cls  = 2'd1;
        end
        tcspq_pkg::CLASS_LO: begin
          incoming.kind = tcspq_pkg::KIND_PUSH;
          incoming.cls  = 2'd2;
        end
        default: begin
          incoming.kind = tcspq_pkg::KIND_BAD;
        end
      endcase
    end
  end

  assign busy       = (cnt == 2'd2);
  assign push       = start && !busy;
  assign qout.valid = (cnt != 2'd0);
  assign qout.work  = q[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (take) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, take};
    end
  end

endmodule

`default_nettype wire

/* sv/tcspq_back.sv */
// back end: per-class fifo pointers and counts, class memories, result register
// depends on tcspq_pkg and tcspq_ram
`default_nettype none

module tcspq_back #(
  parameter int DEPTH = tcspq_pkg::DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tcspq_pkg::qout_t   qout,
  output      logic               take,
  output      logic               done,
  output      tcspq_pkg::result_t result
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  tcspq_pkg::back_state_t      state;
  tcspq_pkg::back_state_t      state_next;
  logic [PTR_W-1:0]            head      [0:2];
  logic [PTR_W-1:0]            head_next [0:2];
  logic [PTR_W-1:0]            tail      [0:2];
  logic [PTR_W-1:0]            tail_next [0:2];
  logic [CNT_W-1:0]            fill      [0:2];
  logic [CNT_W-1:0]            fill_next [0:2];
  logic [1:0]                  pop_cls;
  logic [1:0]                  pop_cls_next;
  logic [tcspq_pkg::TAG_BITS-1:0] rdata [0:2];
  logic                        wr_en;
  logic                        done_next;
  tcspq_pkg::result_t          result_next;
  logic                        found;
  logic [1:0]                  sel;
  logic [1:0]                  c;

  for (genvar k = 0; k < tcspq_pkg::NUM_CLASSES; k++) begin : g_store
    tcspq_ram #(
      .WIDTH (tcspq_pkg::TAG_BITS),
      .DEPTH (DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (wr_en && (c == 2'(k))),
      .waddr (tail[k]),
      .wdata (qout.work.tag),
      .raddr (head[k]),
      .rdata (rdata[k])
    );
  end

  assign c = qout.work.cls;

  // highest-priority non-empty class
  always_comb begin
    found = 1'b0;
    sel   = 2'd0;
    for (int k = tcspq_pkg::NUM_CLASSES - 1; k >= 0; k--) begin
      if (fill[k] != '0) begin
        found = 1'b1;
        sel   = 2'(k);
      end
    end
  end

  always_comb begin
    state_next   = state;
    take         = 1'b0;
    wr_en        = 1'b0;
    done_next    = 1'b0;
    result_next  = '0;
    pop_cls_next = pop_cls;
    head_next    = head;
    tail_next    = tail;
    fill_next    = fill;
    unique case (state)
      tcspq_pkg::BK_RUN: begin
        if (qout.valid) begin
          take = 1'b1;
          unique case (qout.work.kind)
            tcspq_pkg::KIND_BAD: begin
              done_next          = 1'b1;
              result_next.status = tcspq_pkg::ST_BAD_CLASS;
            end
            tcspq_pkg::KIND_PUSH: begin
              done_next = 1'b1;
              if (fill[c] == CNT_W'(DEPTH)) begin
                result_next.status = tcspq_pkg::ST_DROPPED;
              end else begin
                wr_en              = 1'b1;
                tail_next[c]       = (tail[c] == PTR_W'(DEPTH - 1)) ? '0 : tail[c] + 1'b1;
                fill_next[c]       = fill[c] + 1'b1;
                result_next.status = tcspq_pkg::ST_PUSHED;
              end
            end
            tcspq_pkg::KIND_POP: begin
              if (!found) begin
                done_next          = 1'b1;
                result_next.status = tcspq_pkg::ST_EMPTY;
              end else begin
                head_next[sel] = (head[sel] == PTR_W'(DEPTH - 1)) ? '0 : head[sel] + 1'b1;
                fill_next[sel] = fill[sel] - 1'b1;
                pop_cls_next   = sel;
                state_next     = tcspq_pkg::BK_POP;
              end
            end
            default: begin
              done_next          = 1'b1;
              result_next.status = tcspq_pkg::ST_BAD_CLASS;
            end
          endcase
        end
      end
      tcspq_pkg::BK_POP: begin
        // read data of the popped entry is out of the memory now
        done_next             = 1'b1;
        result_next.status    = tcspq_pkg::ST_POPPED;
        result_next.out_tag   = rdata[pop_cls];
        result_next.out_class = pop_cls + 2'd1;
        state_next            = tcspq_pkg::BK_RUN;
      end
      default: begin
        state_next = tcspq_pkg::BK_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcspq_pkg::BK_RUN;
      done  <= 1'b0;
      for (int k = 0; k < tcspq_pkg::NUM_CLASSES; k++) begin
        head[k] <= '0;
        tail[k] <= '0;
        fill[k] <= '0;
      end
    end else begin
      state <= state_next;
      done  <= done_next;
      head  <= head_next;
      tail  <= tail_next;
      fill  <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    pop_cls <= pop_cls_next;
    result  <= result_next;
  end

endmodule

`default_nettype wire

/* sv/three_class_strict_priority_queue.sv */
// top level of the three-class strict priority queue
// depends on tcspq_pkg, tcspq_front, tcspq_back
//
//   channel   handshake        payload     transfer when
//   command   start / busy     cmd         start high and busy low
//   result    done             result      done high (one cycle, no stall)
//
// a push, a rejected push or a pop that finds nothing gives its result from the result
// register once the back end takes it from the queue; a pop that returns a tag passes
// through the BK_POP state as well, for the registered read of the class memory
// sustained rate: one push per cycle, but no command is taken while in BK_POP
// busy rises when the two-entry command queue is full
// reset clears pointers, counts and the queue; the class memories are not cleared
`default_nettype none

module three_class_strict_priority_queue #(
  parameter int DEPTH = tcspq_pkg::DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output      logic               busy,
  input  wire tcspq_pkg::cmd_t    cmd,
  output      logic               done,
  output      tcspq_pkg::result_t result
);

  tcspq_pkg::qout_t qout;
  logic             take;

  tcspq_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .qout  (qout),
    .take  (take)
  );

  tcspq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .qout   (qout),
    .take   (take),
    .done   (done),
    .result (result)
  );

  a_take_nonempty: assert property (@(posedge clk) disable iff (rst)
    take |-> qout.valid)
    else $error("command consumed from empty queue");

  a_busy_has_item: assert property (@(posedge clk) disable iff (rst)
    busy |-> qout.valid)
    else $error("queue full but nothing offered to back end");

  a_zero_unless_popped: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != tcspq_pkg::ST_POPPED) |->
      (result.out_tag == '0 && result.out_class == 2'd0))
    else $error("tag or class set on a result that is not a pop");

  a_popped_class: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == tcspq_pkg::ST_POPPED) |-> (result.out_class != 2'd0))
    else $error("popped result without a class");

endmodule

`default_nettype wire
